FILE: design/subpel_pkg.sv
// package for the sixteenth-pel six-tap interpolator: types, codes and filter taps
`timescale 1ns / 1ps
package subpel_pkg;

  // store geometry defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // signed width for tap coordinates before edge clamping
  localparam int CW = 14;
  // widths of the filter datapath
  localparam int PROD_W = 25;
  localparam int SUM_W  = 32;
  localparam int PIX_W  = 16;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BIT_DEPTH    = 2'd2;

  localparam logic [8:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [8:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [4:0] RST_BIT_DEPTH    = 5'd10;

  localparam logic signed [SUM_W-1:0] ROUND_2D = SUM_W'(2048);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  // per-item settings the filter needs
  typedef struct packed {
    logic [3:0]       fx;
    logic [3:0]       fy;
    logic             copy;
    logic [PIX_W-1:0] maxv;
  } item_ctx_t;

  // travels with each store read
  typedef struct packed {
    logic       valid;
    logic       first_col;
    logic       last_col;
    logic       first_row;
    logic       last;
    logic [2:0] k;
    logic [2:0] j;
  } tap_tag_t;

  localparam logic signed [7:0] TAPS [16][6] = '{
    '{ 8'sd0,   8'sd0,  8'sd64,  8'sd0,   8'sd0,   8'sd0},
    '{ 8'sd1,  -8'sd3,  8'sd63,  8'sd4,  -8'sd2,   8'sd1},
    '{ 8'sd1,  -8'sd5,  8'sd62,  8'sd8,  -8'sd3,   8'sd1},
    '{ 8'sd1,  -8'sd6,  8'sd60,  8'sd13, -8'sd4,   8'sd0},
    '{ 8'sd1,  -8'sd7,  8'sd57,  8'sd19, -8'sd5,  -8'sd1},
    '{ 8'sd1,  -8'sd8,  8'sd54,  8'sd24, -8'sd6,  -8'sd1},
    '{ 8'sd1,  -8'sd9,  8'sd50,  8'sd29, -8'sd6,  -8'sd1},
    '{ 8'sd1,  -8'sd9,  8'sd46,  8'sd35, -8'sd7,  -8'sd2},
    '{ 8'sd1,  -8'sd10, 8'sd42,  8'sd42, -8'sd10,  8'sd1},
    '{-8'sd2,  -8'sd7,  8'sd35,  8'sd46, -8'sd9,   8'sd1},
    '{-8'sd1,  -8'sd6,  8'sd29,  8'sd50, -8'sd9,   8'sd1},
    '{-8'sd1,  -8'sd6,  8'sd24,  8'sd54, -8'sd8,   8'sd1},
    '{-8'sd1,  -8'sd5,  8'sd19,  8'sd57, -8'sd7,   8'sd1},
    '{ 8'sd0,  -8'sd4,  8'sd13,  8'sd60, -8'sd6,   8'sd1},
    '{ 8'sd1,  -8'sd3,  8'sd8,   8'sd62, -8'sd5,   8'sd1},
    '{ 8'sd1,  -8'sd2,  8'sd4,   8'sd63, -8'sd3,   8'sd1}
  };

  function automatic logic signed [7:0] tap_coef(input logic [3:0] ph, input logic [2:0] idx);
    logic signed [7:0] c;
    c = 8'sd0;
    if (idx <= 3'd5) begin
      c = TAPS[ph][idx];
    end
    return c;
  endfunction

endpackage

FILE: design/subpel_six_tap_interpolator_core.sv
// top level of the sixteenth-pel six-tap luma interpolator
`timescale 1ns / 1ps
// Holds one reference luma frame in a single-port store of MAX_WIDTH*MAX_HEIGHT
// 16-bit pixels and answers predict commands with one interpolated sample. A
// command is taken when start is high and busy is low. A write command gives
// no result. A predict reads its tap window from the store one pixel per
// cycle, N reads with N = 1 (both phases zero), 6 (one phase zero) or 36
// (both nonzero); the sample appears on out_predicted_sample with out_valid
// high for one cycle, and busy drops in the cycle after that strobe. A new
// command is only taken once busy has dropped again. The receiver
// cannot stall: a result must be taken in its strobe cycle. Pixels must be
// written before a predict reads them; the store is not cleared at reset.
// Configuration may only be written while busy is low and no result is due.
module subpel_six_tap_interpolator_core
  import subpel_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [7:0]         in_pos_x,
  input  logic [7:0]         in_pos_y,
  input  logic [15:0]        in_pixel_value,
  input  logic signed [15:0] in_mv_x,
  input  logic signed [15:0] in_mv_y,
  output logic               out_valid,
  output logic [15:0]        out_predicted_sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [8:0] frame_width_r, frame_width_nxt;
  logic [8:0] frame_height_r, frame_height_nxt;
  logic [4:0] bit_depth_r, bit_depth_nxt;

  logic             ram_en, ram_we;
  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;
  tap_tag_t         tag;
  item_ctx_t        ctx;
  logic             filt_valid;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    bit_depth_nxt    = bit_depth_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_nxt  = cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_nxt = cfg_wdata;
        CFG_BIT_DEPTH:    bit_depth_nxt    = cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      bit_depth_r    <= RST_BIT_DEPTH;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      bit_depth_r    <= bit_depth_nxt;
    end
  end

  subpel_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .cmd          (in_command),
    .pos_x        (in_pos_x),
    .pos_y        (in_pos_y),
    .pixel_value  (in_pixel_value),
    .mv_x         (in_mv_x),
    .mv_y         (in_mv_y),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .bit_depth    (bit_depth_r),
    .done         (filt_valid),
    .busy         (busy),
    .ram_en       (ram_en),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .tag          (tag),
    .ctx          (ctx)
  );

  subpel_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  subpel_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .tag        (tag),
    .ctx        (ctx),
    .rdata      (ram_rdata),
    .out_valid  (filt_valid),
    .out_sample (out_predicted_sample)
  );

  assign out_valid = filt_valid;

endmodule

FILE: design/subpel_ram.sv
// generic single-port synchronous ram with registered read
`timescale 1ns / 1ps
module subpel_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/subpel_seq.sv
// item sequencer: takes commands, walks the tap window and drives the frame store port
`timescale 1ns / 1ps
module subpel_seq
  import subpel_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  input  logic                                      cmd,
  input  logic [7:0]                                pos_x,
  input  logic [7:0]                                pos_y,
  input  logic [15:0]                               pixel_value,
  input  logic signed [15:0]                        mv_x,
  input  logic signed [15:0]                        mv_y,
  input  logic [8:0]                                frame_width,
  input  logic [8:0]                                frame_height,
  input  logic [4:0]                                bit_depth,
  input  logic                                      done,
  output logic                                      busy,
  output logic                                      ram_en,
  output logic                                      ram_we,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   ram_addr,
  output logic [PIX_W-1:0]                          ram_wdata,
  output tap_tag_t                                  tag,
  output item_ctx_t                                 ctx
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  seq_state_t state_r, state_nxt;
  logic [2:0] k_r, k_nxt, j_r, j_nxt;
  logic signed [CW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [XW-1:0] limx_r, limx_nxt;
  logic [YW-1:0] limy_r, limy_nxt;
  item_ctx_t ctx_r, ctx_nxt;

  logic accept, accept_pred, accept_wr, wr_in_range;
  logic [2:0] kmin, kmax, jmin, jmax;
  logic last_col, last_row;
  logic signed [CW-1:0] xs, ys;
  logic [XW-1:0] xc;
  logic [YW-1:0] yc;
  logic [4:0] bd_sat;
  logic [16:0] maxv_wide;

  assign accept      = start && (state_r == ST_IDLE);
  assign accept_pred = accept && (cmd == CMD_PREDICT);
  assign wr_in_range = (32'(pos_x) < 32'(MAX_WIDTH)) && (32'(pos_y) < 32'(MAX_HEIGHT));
  assign accept_wr   = accept && (cmd == CMD_WRITE) && wr_in_range;
  assign busy        = (state_r != ST_IDLE);

  // a zero phase collapses that axis to the center tap
  assign kmin = (ctx_r.fx == 4'd0) ? 3'd2 : 3'd0;
  assign kmax = (ctx_r.fx == 4'd0) ? 3'd2 : 3'd5;
  assign jmin = (ctx_r.fy == 4'd0) ? 3'd2 : 3'd0;
  assign jmax = (ctx_r.fy == 4'd0) ? 3'd2 : 3'd5;
  assign last_col = (k_r == kmax);
  assign last_row = (j_r == jmax);

  always_comb begin
    bd_sat = bit_depth;
    if (bit_depth < 5'd8) begin
      bd_sat = 5'd8;
    end else if (bit_depth > 5'd16) begin
      bd_sat = 5'd16;
    end
    maxv_wide = (17'd1 << bd_sat) - 17'd1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_pred) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_col && last_row) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // item context and tap counters
  always_comb begin
    k_nxt    = k_r;
    j_nxt    = j_r;
    ox_nxt   = ox_r;
    oy_nxt   = oy_r;
    limx_nxt = limx_r;
    limy_nxt = limy_r;
    ctx_nxt  = ctx_r;
    if (accept_pred) begin
      ox_nxt = {{(CW-8){1'b0}}, pos_x} + {{(CW-12){mv_x[15]}}, mv_x[15:4]};
      oy_nxt = {{(CW-8){1'b0}}, pos_y} + {{(CW-12){mv_y[15]}}, mv_y[15:4]};
      if (frame_width == 9'd0) begin
        limx_nxt = '0;
      end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
        limx_nxt = XW'(MAX_WIDTH - 1);
      end else begin
        limx_nxt = XW'(frame_width - 9'd1);
      end
      if (frame_height == 9'd0) begin
        limy_nxt = '0;
      end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
        limy_nxt = YW'(MAX_HEIGHT - 1);
      end else begin
        limy_nxt = YW'(frame_height - 9'd1);
      end
      ctx_nxt.fx   = mv_x[3:0];
      ctx_nxt.fy   = mv_y[3:0];
      ctx_nxt.copy = (mv_x[3:0] == 4'd0) && (mv_y[3:0] == 4'd0);
      ctx_nxt.maxv = maxv_wide[15:0];
      k_nxt = (mv_x[3:0] == 4'd0) ? 3'd2 : 3'd0;
      j_nxt = (mv_y[3:0] == 4'd0) ? 3'd2 : 3'd0;
    end else if (state_r == ST_RUN) begin
      if (last_col) begin
        k_nxt = kmin;
        j_nxt = j_r + 3'd1;
      end else begin
        k_nxt = k_r + 3'd1;
      end
    end
  end

  // clamp the current tap to the frame
  always_comb begin
    xs = ox_r + {{(CW-3){1'b0}}, k_r} - CW'(2);
    ys = oy_r + {{(CW-3){1'b0}}, j_r} - CW'(2);
    if (xs[CW-1]) begin
      xc = '0;
    end else if (xs > $signed({{(CW-XW){1'b0}}, limx_r})) begin
      xc = limx_r;
    end else begin
      xc = xs[XW-1:0];
    end
    if (ys[CW-1]) begin
      yc = '0;
    end else if (ys > $signed({{(CW-YW){1'b0}}, limy_r})) begin
      yc = limy_r;
    end else begin
      yc = ys[YW-1:0];
    end
  end

  // store port and tap tag
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(yc) * AW'(MAX_WIDTH) + AW'(xc);
    ram_wdata = pixel_value;
    tag       = '0;
    if (accept_wr) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = AW'(pos_y) * AW'(MAX_WIDTH) + AW'(pos_x);
    end else if (state_r == ST_RUN) begin
      ram_en         = 1'b1;
      tag.valid      = 1'b1;
      tag.first_col  = (k_r == kmin);
      tag.last_col   = last_col;
      tag.first_row  = (j_r == jmin);
      tag.last       = last_col && last_row;
      tag.k          = k_r;
      tag.j          = j_r;
    end
  end

  assign ctx = ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    limx_r <= limx_nxt;
    limy_r <= limy_nxt;
    ctx_r  <= ctx_nxt;
  end

endmodule

FILE: design/subpel_filter.sv
// separable six-tap filter pipeline: horizontal mac, vertical mac, round and clamp
`timescale 1ns / 1ps
module subpel_filter
  import subpel_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  tap_tag_t         tag,
  input  item_ctx_t        ctx,
  input  logic [PIX_W-1:0] rdata,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_sample
);

  tap_tag_t t1_r, t2_r, t3_r, t4_r;
  tap_tag_t t2_nxt, t3_nxt, t4_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, row_r, row_nxt, rdone_r, rdone_nxt;
  logic signed [PROD_W-1:0] row_sum;
  logic signed [SUM_W-1:0] vprod_r, vprod_nxt, tot_r, tot_nxt;
  logic fin_r, fin_nxt, out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_sample_r, out_sample_nxt;
  logic [19:0] shifted;

  always_comb begin
    // stage 1: pixel times horizontal tap
    prod_nxt = prod_r;
    t2_nxt   = t1_r;
    if (t1_r.valid) begin
      prod_nxt = PROD_W'($signed({1'b0, rdata})) * PROD_W'(tap_coef(ctx.fx, t1_r.k));
    end

    // stage 2: horizontal accumulate, hand finished rows on
    row_sum   = (t2_r.first_col ? '0 : row_r) + prod_r;
    row_nxt   = row_r;
    rdone_nxt = rdone_r;
    t3_nxt    = t2_r;
    t3_nxt.valid = t2_r.valid && t2_r.last_col;
    if (t2_r.valid) begin
      row_nxt = row_sum;
      if (t2_r.last_col) begin
        rdone_nxt = row_sum;
      end
    end

    // stage 3: row sum times vertical tap
    vprod_nxt = vprod_r;
    t4_nxt    = t3_r;
    if (t3_r.valid) begin
      vprod_nxt = SUM_W'(rdone_r) * SUM_W'(tap_coef(ctx.fy, t3_r.j));
    end

    // stage 4: vertical accumulate with the rounding offset
    tot_nxt = tot_r;
    fin_nxt = t4_r.valid && t4_r.last;
    if (t4_r.valid) begin
      tot_nxt = (t4_r.first_row ? ROUND_2D : tot_r) + vprod_r;
    end

    // stage 5: shift, clamp; single-axis cases carry a factor of 64 from the center tap
    shifted        = tot_r[SUM_W-1:12];
    out_valid_nxt  = fin_r;
    out_sample_nxt = out_sample_r;
    if (fin_r) begin
      if (tot_r[SUM_W-1]) begin
        out_sample_nxt = '0;
      end else if (ctx.copy) begin
        out_sample_nxt = shifted[PIX_W-1:0];
      end else if (shifted > {4'd0, ctx.maxv}) begin
        out_sample_nxt = ctx.maxv;
      end else begin
        out_sample_nxt = shifted[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r        <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      t4_r        <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t1_r        <= tag;
      t2_r        <= t2_nxt;
      t3_r        <= t3_nxt;
      t4_r        <= t4_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    row_r        <= row_nxt;
    rdone_r      <= rdone_nxt;
    vprod_r      <= vprod_nxt;
    tot_r        <= tot_nxt;
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

FILE: test/subpel_six_tap_interpolator_core_tb.sv
// self-checking testbench for the sixteenth-pel six-tap interpolator core
`timescale 1ns / 1ps
module subpel_six_tap_interpolator_core_tb
  import subpel_pkg::*;
();

  localparam int STORE_W = DEF_MAX_WIDTH;
  localparam int STORE_H = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 400;
  localparam int RANDOM_PHASES = 6;
  // index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  localparam int PHASE_TAPS [16][6] = '{
    '{ 0,   0, 64,  0,   0,  0},
    '{ 1,  -3, 63,  4,  -2,  1},
    '{ 1,  -5, 62,  8,  -3,  1},
    '{ 1,  -6, 60, 13,  -4,  0},
    '{ 1,  -7, 57, 19,  -5, -1},
    '{ 1,  -8, 54, 24,  -6, -1},
    '{ 1,  -9, 50, 29,  -6, -1},
    '{ 1,  -9, 46, 35,  -7, -2},
    '{ 1, -10, 42, 42, -10,  1},
    '{-2,  -7, 35, 46,  -9,  1},
    '{-1,  -6, 29, 50,  -9,  1},
    '{-1,  -6, 24, 54,  -8,  1},
    '{-1,  -5, 19, 57,  -7,  1},
    '{ 0,  -4, 13, 60,  -6,  1},
    '{ 1,  -3,  8, 62,  -5,  1},
    '{ 1,  -2,  4, 63,  -3,  1}
  };

  typedef struct {
    logic [15:0]        sample;
    logic [7:0]         x;
    logic [7:0]         y;
    logic signed [15:0] mvx;
    logic signed [15:0] mvy;
  } sample_exp_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_command;
  logic [7:0]         in_pos_x;
  logic [7:0]         in_pos_y;
  logic [15:0]        in_pixel_value;
  logic signed [15:0] in_mv_x;
  logic signed [15:0] in_mv_y;
  logic               out_valid;
  logic [15:0]        out_predicted_sample;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [8:0]         cfg_wdata;

  // predictor state
  logic [15:0] frame_copy [STORE_W*STORE_H];
  bit          pixel_written [STORE_W*STORE_H];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [4:0]  depth_reg;

  sample_exp_t pending_samples [$];
  int          mismatch_count;
  bit          idle_allowed;
  int          hot_x;
  int          hot_y;

  subpel_six_tap_interpolator_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_pixel_value       (in_pixel_value),
    .in_mv_x              (in_mv_x),
    .in_mv_y              (in_mv_y),
    .out_valid            (out_valid),
    .out_predicted_sample (out_predicted_sample),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int usable_dim(logic [8:0] v, int maxd);
    if (v == 9'd0) return 1;
    if (int'(v) > maxd) return maxd;
    return int'(v);
  endfunction

  function automatic int usable_depth();
    if (depth_reg < 5'd8) return 8;
    if (depth_reg > 5'd16) return 16;
    return int'(depth_reg);
  endfunction

  function automatic int bound_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // store address of a tap after edge clamping
  function automatic int store_addr(int x, int y);
    int cx;
    int cy;
    cx = bound_int(x, 0, usable_dim(width_reg, STORE_W) - 1);
    cy = bound_int(y, 0, usable_dim(height_reg, STORE_H) - 1);
    return cy * STORE_W + cx;
  endfunction

  function automatic longint round_clip(longint sum, int shift, longint maxv);
    longint r;
    if (sum < 0) return 0;
    r = sum >>> shift;
    if (r > maxv) return maxv;
    return r;
  endfunction

  function automatic logic [15:0] predict_sample(input logic [7:0] bx, input logic [7:0] by,
                                                 input logic signed [15:0] mvx,
                                                 input logic signed [15:0] mvy);
    int     fx;
    int     fy;
    int     ox;
    int     oy;
    int     j;
    int     k;
    longint maxv;
    longint acc;
    longint part;
    fx = int'(mvx[3:0]);
    fy = int'(mvy[3:0]);
    ox = int'(bx) + (int'(mvx) >>> 4);
    oy = int'(by) + (int'(mvy) >>> 4);
    maxv = (longint'(1) << usable_depth()) - 1;
    // plain copy keeps the stored value, no clamp to the bit depth
    if (fx == 0 && fy == 0) return frame_copy[store_addr(ox, oy)];
    if (fx == 0) begin
      acc = 32;
      for (k = 0; k < 6; k++)
        acc += longint'(frame_copy[store_addr(ox, oy + k - 2)]) * PHASE_TAPS[fy][k];
      return 16'(round_clip(acc, 6, maxv));
    end
    if (fy == 0) begin
      acc = 32;
      for (k = 0; k < 6; k++)
        acc += longint'(frame_copy[store_addr(ox + k - 2, oy)]) * PHASE_TAPS[fx][k];
      return 16'(round_clip(acc, 6, maxv));
    end
    // horizontal sums stay unrounded before the vertical pass
    acc = 2048;
    for (j = 0; j < 6; j++) begin
      part = 0;
      for (k = 0; k < 6; k++)
        part += longint'(frame_copy[store_addr(ox + k - 2, oy + j - 2)]) * PHASE_TAPS[fx][k];
      acc += part * PHASE_TAPS[fy][j];
    end
    return 16'(round_clip(acc, 12, maxv));
  endfunction

  function automatic logic [15:0] fresh_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, (1 << usable_depth()) - 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] random_mv();
    logic signed [15:0] m;
    case ($urandom_range(0, 9))
      0: m = 16'($urandom);
      1: m = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: begin
        // a few pels either way, sometimes on the integer grid
        m = 16'($urandom_range(0, 191)) - 16'sd96;
        if ($urandom_range(0, 3) == 0) m[3:0] = 4'd0;
      end
    endcase
    return m;
  endfunction

  function automatic logic [7:0] pick_pos(int hot, int dim);
    case ($urandom_range(0, 7))
      0: return 8'($urandom);
      1: return 8'(bound_int(dim - 1 - int'($urandom_range(0, 2)), 0, 255));
      2: return 8'($urandom_range(0, 2));
      default: return 8'(hot + int'($urandom_range(0, 15)));
    endcase
  endfunction

  function automatic logic [8:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 9'd0;
      1: return 9'd1;
      2: return 9'd256;
      3: return 9'd511;
      4: return 9'($urandom);
      default: return 9'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] error: %s", $time, what);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                           input logic [15:0] value, input logic signed [15:0] mvx,
                           input logic signed [15:0] mvy);
    sample_exp_t e;
    int          gap;
    in_command     <= cmd;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pixel_value <= value;
    in_mv_x        <= mvx;
    in_mv_y        <= mvy;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    if (cmd == CMD_WRITE) begin
      frame_copy[int'(y) * STORE_W + int'(x)] = value;
      pixel_written[int'(y) * STORE_W + int'(x)] = 1'b1;
    end else begin
      e.sample = predict_sample(x, y, mvx, mvy);
      e.x = x;
      e.y = y;
      e.mvx = mvx;
      e.mvy = mvy;
      pending_samples.push_back(e);
    end
    gap = 0;
    if (idle_allowed && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_pixel(input logic [7:0] x, input logic [7:0] y, input logic [15:0] value);
    send_item(CMD_WRITE, x, y, value, 16'($urandom), 16'($urandom));
  endtask

  // fills every store entry the predict will read that holds nothing yet
  task automatic cover_window(input logic [7:0] bx, input logic [7:0] by,
                              input logic signed [15:0] mvx, input logic signed [15:0] mvy);
    int ox;
    int oy;
    int lo_x;
    int hi_x;
    int lo_y;
    int hi_y;
    int i;
    int j;
    int a;
    ox = int'(bx) + (int'(mvx) >>> 4);
    oy = int'(by) + (int'(mvy) >>> 4);
    lo_x = (mvx[3:0] == 4'd0) ? 0 : -2;
    hi_x = (mvx[3:0] == 4'd0) ? 0 : 3;
    lo_y = (mvy[3:0] == 4'd0) ? 0 : -2;
    hi_y = (mvy[3:0] == 4'd0) ? 0 : 3;
    for (j = lo_y; j <= hi_y; j++) begin
      for (i = lo_x; i <= hi_x; i++) begin
        a = store_addr(ox + i, oy + j);
        if (!pixel_written[a]) write_pixel(8'(a % STORE_W), 8'(a / STORE_W), fresh_pixel());
      end
    end
  endtask

  task automatic predict_item(input logic [7:0] bx, input logic [7:0] by,
                              input logic signed [15:0] mvx, input logic signed [15:0] mvy);
    cover_window(bx, by, mvx, mvy);
    send_item(CMD_PREDICT, bx, by, 16'($urandom), mvx, mvy);
  endtask

  // a write item gives no result, so wait out the block's own latency too
  task automatic settle_block();
    start <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [8:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      CFG_BIT_DEPTH:    depth_reg = value[4:0];
      default: ;
    endcase
  endtask

  task automatic random_item();
    if ($urandom_range(0, 9) < 2) begin
      write_pixel(8'($urandom), 8'($urandom), fresh_pixel());
    end else begin
      predict_item(pick_pos(hot_x, usable_dim(width_reg, STORE_W)),
                   pick_pos(hot_y, usable_dim(height_reg, STORE_H)),
                   random_mv(), random_mv());
    end
  endtask

  task automatic test_copy_extremes();
    write_pixel(8'd0, 8'd0, 16'hFFFF);
    write_pixel(8'd255, 8'd255, 16'h0000);
    write_pixel(8'd255, 8'd0, 16'h8000);
    write_pixel(8'd0, 8'd255, 16'h7FFF);
    predict_item(8'd0, 8'd0, 16'sh0000, 16'sh0000);
    predict_item(8'd255, 8'd0, 16'sh0000, 16'sh0000);
    // huge offsets clamp the taps to the corners; the last one has nonzero phases
    predict_item(8'd0, 8'd0, 16'sh8000, 16'sh8000);
    predict_item(8'd0, 8'd255, 16'sh7FF0, 16'sh7FF0);
    predict_item(8'd255, 8'd255, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_single_axis();
    int ph;
    for (ph = 1; ph < 16; ph++) begin
      if (ph % 2 == 1) predict_item(8'd40, 8'd40, 16'(ph), 16'sh0000);
      else predict_item(8'd40, 8'd40, 16'sh0000, 16'(ph - 32));
    end
    // big pixel under a negative tap drives the sum below zero
    write_pixel(8'd41, 8'd60, 16'h0000);
    write_pixel(8'd42, 8'd60, 16'hFFFF);
    write_pixel(8'd43, 8'd60, 16'h0000);
    write_pixel(8'd44, 8'd60, 16'h0000);
    write_pixel(8'd45, 8'd60, 16'h0000);
    write_pixel(8'd46, 8'd60, 16'h0000);
    predict_item(8'd43, 8'd60, 16'sh0008, 16'sh0000);
  endtask

  task automatic test_two_axis();
    predict_item(8'd40, 8'd40, 16'sh0011, 16'sh0023);
    predict_item(8'd40, 8'd40, 16'shFFFF, 16'shFFFF);
    predict_item(8'd40, 8'd40, 16'sh0088, 16'shFF78);
  endtask

  task automatic test_frame_config();
    write_register(CFG_FRAME_WIDTH, 9'd4);
    write_register(CFG_FRAME_HEIGHT, 9'd4);
    // stored but outside the frame, edge clamping must never reach it
    write_pixel(8'd200, 8'd200, 16'hFFFF);
    predict_item(8'd3, 8'd3, 16'sh0011, 16'sh0011);
    predict_item(8'd200, 8'd200, 16'sh0000, 16'sh0000);
    write_register(CFG_FRAME_WIDTH, 9'd0);
    write_register(CFG_FRAME_HEIGHT, 9'd0);
    predict_item(8'd5, 8'd5, 16'sh0018, 16'sh0028);
    write_register(CFG_FRAME_WIDTH, 9'd511);
    write_register(CFG_FRAME_HEIGHT, 9'd300);
    predict_item(8'd250, 8'd250, 16'sh0035, 16'sh0000);
    write_register(CFG_BIT_DEPTH, 9'd0);
    predict_item(8'd0, 8'd0, 16'sh0008, 16'sh0008);
    write_register(CFG_BIT_DEPTH, 9'd31);
    predict_item(8'd0, 8'd0, 16'sh0008, 16'sh0000);
    write_register(CFG_BIT_DEPTH, 9'd8);
    predict_item(8'd0, 8'd0, 16'sh0000, 16'sh0000);
    write_register(CFG_BIT_DEPTH, 9'd16);
    predict_item(8'd1, 8'd1, 16'sh0004, 16'sh000C);
    write_register(CFG_SPARE, 9'h1AA);
    predict_item(8'd1, 8'd1, 16'sh0000, 16'sh0007);
    write_register(CFG_FRAME_WIDTH, 9'd256);
    write_register(CFG_FRAME_HEIGHT, 9'd256);
    write_register(CFG_BIT_DEPTH, 9'd10);
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase > 0) begin
        write_register(CFG_FRAME_WIDTH, pick_dim());
        write_register(CFG_FRAME_HEIGHT, pick_dim());
        case ($urandom_range(0, 5))
          0: write_register(CFG_BIT_DEPTH, 9'd8);
          1: write_register(CFG_BIT_DEPTH, 9'd16);
          2: write_register(CFG_BIT_DEPTH, 9'($urandom));
          default: write_register(CFG_BIT_DEPTH, 9'($urandom_range(8, 16)));
        endcase
      end
      hot_x = $urandom_range(0, 255);
      hot_y = $urandom_range(0, 255);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) random_item();
    end
  endtask

  task automatic test_back_to_back();
    idle_allowed = 1'b0;
    hot_x = $urandom_range(0, 255);
    hot_y = $urandom_range(0, 255);
    repeat (40) random_item();
  endtask

  always @(posedge clk) begin : check_samples
    sample_exp_t e;
    if (rst_n && out_valid) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %h with no predict waiting", out_predicted_sample));
      end else begin
        e = pending_samples.pop_front();
        if (out_predicted_sample !== e.sample)
          report_mismatch($sformatf("pos (%0d,%0d) mv (%0d,%0d): sample %h, want %h",
                                    e.x, e.y, e.mvx, e.mvy, out_predicted_sample, e.sample));
      end
    end
  end

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_command     <= CMD_WRITE;
    in_pos_x       <= 8'd0;
    in_pos_y       <= 8'd0;
    in_pixel_value <= 16'd0;
    in_mv_x        <= 16'sd0;
    in_mv_y        <= 16'sd0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FRAME_WIDTH;
    cfg_wdata      <= 9'd0;
    mismatch_count = 0;
    idle_allowed   = 1'b1;
    hot_x          = 40;
    hot_y          = 40;
    width_reg      = RST_FRAME_WIDTH;
    height_reg     = RST_FRAME_HEIGHT;
    depth_reg      = RST_BIT_DEPTH;
    for (int a = 0; a < STORE_W * STORE_H; a++) begin
      frame_copy[a] = 16'd0;
      pixel_written[a] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_copy_extremes();
    test_single_axis();
    test_two_axis();
    test_frame_config();
    test_random_traffic();
    test_back_to_back();
    settle_block();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
